// File: design/cpts_pkg.sv
// Shared types and constants for the counter/priority task scheduler.
// No dependencies; every other design file imports this package.
`default_nettype none

package cpts_pkg;

   localparam int FUNC_W = 3;
   localparam int TASK_W = 6;
   localparam int PRIO_W = 8;
   localparam int CNT_W  = 16;
   localparam int PRE_W  = 8;

   // Event codes carried in func.
   localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_YIELD = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXIT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PDIS  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PEN   = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd5;

   localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
   localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
   localparam logic [PRE_W-1:0]        PRE_MAX = 8'hFF;

   // One task table entry as held in the slot memory.
   typedef struct packed {
      logic signed [CNT_W-1:0] counter;
      logic [PRIO_W-1:0]       prio;
      logic [PRE_W-1:0]        preempt;
   } slot_word_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [TASK_W-1:0] task_index;
      logic [PRIO_W-1:0] task_priority;
   } event_type;

   typedef struct packed {
      logic [TASK_W-1:0]       current_task;
      logic                    switched;
      logic signed [CNT_W-1:0] current_counter;
   } result_type;

endpackage

`default_nettype wire

// File: design/cpts_req_if.sv
// Event channel: valid/ready handshake plus the event payload.
// Depends on cpts_pkg for field widths.
`default_nettype none

interface cpts_req_if import cpts_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [TASK_W-1:0] task_index;
   logic [PRIO_W-1:0] task_priority;

   modport source (output valid, output func, output task_index, output task_priority,
                   input ready);
   modport sink   (input valid, input func, input task_index, input task_priority,
                   output ready);
endinterface

`default_nettype wire

// File: design/cpts_rsp_if.sv
// Result channel: valid/ready handshake plus the scheduling result payload.
// Depends on cpts_pkg for field widths.
`default_nettype none

interface cpts_rsp_if import cpts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [TASK_W-1:0]       current_task;
   logic                    switched;
   logic signed [CNT_W-1:0] current_counter;

   modport source (output valid, output current_task, output switched,
                   output current_counter, input ready);
   modport sink   (input valid, input current_task, input switched,
                   input current_counter, output ready);
endinterface

`default_nettype wire

// File: design/cpts_slot_mem.sv
// Slot memory: counter, priority and preempt count per task, one read and
// one write port, registered read. Per-entry written flags supply reset values.
`default_nettype none

module cpts_slot_mem import cpts_pkg::*; #(
   parameter int  TASKS  = 64,
   localparam int SLOT_W = $clog2(TASKS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SLOT_W-1:0] rd_addr,
   output slot_word_type          rd_data,
   input  wire logic              wr_en,
   input  wire logic [SLOT_W-1:0] wr_addr,
   input  wire slot_word_type     wr_data
);

   slot_word_type     mem [TASKS];
   slot_word_type     q_ff;
   logic [SLOT_W-1:0] rd_addr_ff;
   logic [TASKS-1:0]  written_ff, written_in;
   logic              rd_written_ff, rd_written_in;
   slot_word_type     reset_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff       <= mem[rd_addr];
      rd_addr_ff <= rd_addr;
   end

   always_comb begin
      written_in = written_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
      rd_written_in = written_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         written_ff    <= written_in;
         rd_written_ff <= rd_written_in;
      end
   end

   // Unwritten entries read as their reset value: slot 0 has priority 1.
   always_comb begin
      reset_word.counter = '0;
      reset_word.prio    = (rd_addr_ff == '0) ? PRIO_W'(1) : '0;
      reset_word.preempt = '0;
      rd_data = rd_written_ff ? q_ff : reset_word;
   end

endmodule

`default_nettype wire

// File: design/cpts_sched.sv
// Event sequencer: read-modify-write of the current slot, scan and recharge
// passes over the slot memory. Depends on cpts_pkg; drives cpts_slot_mem.
`default_nettype none

module cpts_sched import cpts_pkg::*; #(
   parameter int  TASKS  = 64,
   localparam int SLOT_W = $clog2(TASKS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire event_type          evt,
   output logic                    ready,
   output logic                    res_valid,
   output result_type              res,
   input  wire logic               res_take,
   output logic [SLOT_W-1:0]       rd_addr,
   input  wire slot_word_type      rd_data,
   output logic                    wr_en,
   output logic [SLOT_W-1:0]       wr_addr,
   output slot_word_type           wr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CUR,
      ST_SCAN,
      ST_PICK_RD,
      ST_PICK_DATA,
      ST_DONE
   } state_type;

   localparam logic [SLOT_W:0]   ISSUE_END = (SLOT_W+1)'(TASKS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASKS - 1);

   state_type               state_ff, state_in;
   event_type               evt_ff, evt_in;
   logic [SLOT_W-1:0]       cur_ff, cur_in;
   logic [SLOT_W-1:0]       before_ff, before_in;
   logic [TASKS-1:0]        valid_ff, valid_in;
   logic [TASKS-1:0]        run_ff, run_in;
   logic [SLOT_W:0]         issue_ff, issue_in;
   logic                    dvld_ff, dvld_in;
   logic [SLOT_W-1:0]       didx_ff, didx_in;
   logic signed [CNT_W:0]   best_ff, best_in;
   logic [SLOT_W-1:0]       pick_ff, pick_in;
   logic                    rech_ff, rech_in;
   result_type              res_ff, res_in;

   logic signed [CNT_W-1:0] rd_cnt, tick_dec, half, recharged, cand;
   logic signed [CNT_W:0]   rsum, cand_x, best_nx;
   logic [SLOT_W-1:0]       pick_nx, load_slot;
   logic                    hit, load_ok;

   assign rd_cnt    = rd_data.counter;
   assign tick_dec  = (rd_cnt == CNT_MIN) ? rd_cnt : rd_cnt - 16'sd1;
   assign half      = rd_cnt >>> 1;
   assign rsum      = {half[CNT_W-1], half} + {{(CNT_W+1-PRIO_W){1'b0}}, rd_data.prio};
   assign recharged = (!rsum[CNT_W] && rsum[CNT_W-1]) ? CNT_MAX : rsum[CNT_W-1:0];
   assign cand      = rech_ff ? recharged : rd_cnt;
   assign cand_x    = {cand[CNT_W-1], cand};
   assign hit       = valid_ff[didx_ff] && run_ff[didx_ff] && (cand_x > best_ff);
   assign best_nx   = hit ? cand_x : best_ff;
   assign pick_nx   = hit ? didx_ff : pick_ff;
   assign load_slot = SLOT_W'(evt_ff.task_index);
   assign load_ok   = 32'(evt_ff.task_index) < 32'(TASKS);

   assign ready     = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res       = res_ff;

   always_comb begin
      state_in  = state_ff;
      evt_in    = evt_ff;
      cur_in    = cur_ff;
      before_in = before_ff;
      valid_in  = valid_ff;
      run_in    = run_ff;
      issue_in  = issue_ff;
      dvld_in   = 1'b0;
      didx_in   = didx_ff;
      best_in   = best_ff;
      pick_in   = pick_ff;
      rech_in   = rech_ff;
      res_in    = res_ff;
      rd_addr   = cur_ff;
      wr_en     = 1'b0;
      wr_addr   = cur_ff;
      wr_data   = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               evt_in    = evt;
               before_in = cur_ff;
               state_in  = ST_CUR;
            end
         end
         ST_CUR: begin
            res_in.current_task    = TASK_W'(cur_ff);
            res_in.switched        = 1'b0;
            res_in.current_counter = rd_cnt;
            state_in               = ST_DONE;
            issue_in               = '0;
            best_in                = -(CNT_W+1)'(1);
            pick_in                = '0;
            rech_in                = 1'b0;
            unique case (evt_ff.func)
               FUNC_TICK: begin
                  wr_en = 1'b1;
                  if (tick_dec > 16'sd0 || rd_data.preempt != '0) begin
                     wr_data.counter        = tick_dec;
                     res_in.current_counter = tick_dec;
                  end else begin
                     wr_data.counter = '0;
                     state_in        = ST_SCAN;
                  end
               end
               FUNC_YIELD: begin
                  wr_en           = 1'b1;
                  wr_data.counter = '0;
                  state_in        = ST_SCAN;
               end
               FUNC_EXIT: begin
                  wr_en           = 1'b1;
                  wr_data.counter = '0;
                  run_in[cur_ff]  = 1'b0;
                  state_in        = ST_SCAN;
               end
               FUNC_PDIS: begin
                  wr_en = 1'b1;
                  if (rd_data.preempt != PRE_MAX) begin
                     wr_data.preempt = rd_data.preempt + PRE_W'(1);
                  end
               end
               FUNC_PEN: begin
                  wr_en = 1'b1;
                  if (rd_data.preempt != '0) begin
                     wr_data.preempt = rd_data.preempt - PRE_W'(1);
                  end
               end
               FUNC_LOAD: begin
                  if (load_ok) begin
                     wr_en               = 1'b1;
                     wr_addr             = load_slot;
                     wr_data.counter     = {{(CNT_W-PRIO_W){1'b0}}, evt_ff.task_priority};
                     wr_data.prio        = evt_ff.task_priority;
                     wr_data.preempt     = '0;
                     valid_in[load_slot] = 1'b1;
                     run_in[load_slot]   = 1'b1;
                     if (load_slot == cur_ff) begin
                        res_in.current_counter =
                           {{(CNT_W-PRIO_W){1'b0}}, evt_ff.task_priority};
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SCAN: begin
            rd_addr = issue_ff[SLOT_W-1:0];
            if (issue_ff < ISSUE_END) begin
               issue_in = issue_ff + (SLOT_W+1)'(1);
               dvld_in  = 1'b1;
               didx_in  = issue_ff[SLOT_W-1:0];
            end
            if (dvld_ff) begin
               best_in = best_nx;
               pick_in = pick_nx;
               // Recharge pass writes each valid slot back as it is compared.
               if (rech_ff && valid_ff[didx_ff]) begin
                  wr_en           = 1'b1;
                  wr_addr         = didx_ff;
                  wr_data.counter = recharged;
               end
               if (didx_ff == LAST_SLOT) begin
                  if (!rech_ff && best_nx == '0) begin
                     rech_in  = 1'b1;
                     issue_in = '0;
                     dvld_in  = 1'b0;
                     best_in  = -(CNT_W+1)'(1);
                     pick_in  = '0;
                  end else begin
                     cur_in   = pick_nx;
                     state_in = ST_PICK_RD;
                  end
               end
            end
         end
         ST_PICK_RD: begin
            rd_addr  = cur_ff;
            state_in = ST_PICK_DATA;
         end
         ST_PICK_DATA: begin
            res_in.current_task    = TASK_W'(cur_ff);
            res_in.switched        = (cur_ff != before_ff);
            res_in.current_counter = rd_cnt;
            state_in               = ST_DONE;
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cur_ff    <= '0;
         before_ff <= '0;
         valid_ff  <= TASKS'(1);
         run_ff    <= TASKS'(1);
         issue_ff  <= '0;
         dvld_ff   <= 1'b0;
         rech_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cur_ff    <= cur_in;
         before_ff <= before_in;
         valid_ff  <= valid_in;
         run_ff    <= run_in;
         issue_ff  <= issue_in;
         dvld_ff   <= dvld_in;
         rech_ff   <= rech_in;
      end
      evt_ff  <= evt_in;
      didx_ff <= didx_in;
      best_ff <= best_in;
      pick_ff <= pick_in;
      res_ff  <= res_in;
   end

endmodule

`default_nettype wire

// File: design/counter_priority_task_scheduler.sv
// Tick without reschedule, preempt, load and unused codes go from ST_CUR to ST_DONE; a reschedule
// adds a scan pass over every slot, a recharge pass when the best counter is zero, then ST_PICK_RD and ST_PICK_DATA.
// Throughput: one event at a time; the slot memory port, one slot per cycle, sets the scan.
// The output register takes a finished result so the next event can be accepted at once.
// Reset (synchronous, active high): slot 0 valid and running with priority 1, current 0;
// memory entries read as reset values until written, with no clearing pass.
`default_nettype none

module counter_priority_task_scheduler import cpts_pkg::*; #(
   parameter int TASKS = 64
) (
   input wire logic  clock,
   input wire logic  reset,
   cpts_req_if.sink   req_chan,
   cpts_rsp_if.source rsp_chan
);

   localparam int SLOT_W = $clog2(TASKS);

   event_type         evt;
   logic              start;
   logic              eng_ready;
   logic              eng_res_valid;
   result_type        eng_res;
   logic              res_take;
   logic [SLOT_W-1:0] rd_addr;
   slot_word_type     rd_data;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;
   slot_word_type     wr_data;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;

   // Pack the event beat; the sequencer captures it when it starts.
   assign evt.func          = req_chan.func;
   assign evt.task_index    = req_chan.task_index;
   assign evt.task_priority = req_chan.task_priority;
   assign req_chan.ready    = eng_ready;
   assign start             = req_chan.valid && eng_ready;

   cpts_sched #(.TASKS(TASKS)) u_sched (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .evt       (evt),
      .ready     (eng_ready),
      .res_valid (eng_res_valid),
      .res       (eng_res),
      .res_take  (res_take),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   cpts_slot_mem #(.TASKS(TASKS)) u_slot_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Output register: take a result when the register is empty or its beat
   // leaves in this cycle; otherwise hold the sequencer in its done state.
   assign res_take = eng_res_valid && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (res_take) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.current_task    = rsp_data_ff.current_task;
   assign rsp_chan.switched        = rsp_data_ff.switched;
   assign rsp_chan.current_counter = rsp_data_ff.current_counter;

`ifndef ASSERT_OFF
   // The sequencer works on one event: no beat can follow in the next cycle.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("event accepted while previous event still in progress");

   // A pending sequencer result holds until the output register takes it.
   a_res_hold: assert property (@(posedge clock) disable iff (reset)
      (eng_res_valid && !res_take) |=> (eng_res_valid && $stable(eng_res)))
      else $error("sequencer result dropped or changed before handoff");

   // A new result beat appears only from a handoff.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(res_take))
      else $error("result beat appeared without a handoff");

   // A handoff always leaves a beat in the output register.
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      res_take |=> rsp_valid_ff)
      else $error("handoff lost");
`endif

endmodule

`default_nettype wire
